[sv/frustum_box_cull_defines.svh]
// assertion macros for the frustum box cull block
`ifndef FRUSTUM_BOX_CULL_DEFINES_SVH
`define FRUSTUM_BOX_CULL_DEFINES_SVH

// condition checked on the same edge
`define FBC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition checked on the following edge
`define FBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/fbc_pkg.sv]
// package: sizes, register indexes, plane codes and reset matrix for frustum box cull
package fbc_pkg;

    localparam int FBC_COORD_WIDTH = 32;
    localparam int FBC_FRAC_BITS   = 16;

    localparam int COORD_PORT_W = 32;
    localparam int CFG_DATA_W   = 64;
    localparam int NUM_REGS     = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int NUM_PLANES   = 6;
    localparam int NUM_COMPS    = 4;
    localparam int NUM_AXES     = 3;
    localparam int MASK_W       = NUM_PLANES;

    // register indexes
    localparam int REG_COL0_ROWS01 = 0;
    localparam int REG_COL0_ROWS23 = 1;
    localparam int REG_COL1_ROWS01 = 2;
    localparam int REG_COL1_ROWS23 = 3;
    localparam int REG_COL2_ROWS01 = 4;
    localparam int REG_COL2_ROWS23 = 5;
    localparam int REG_COL3_ROWS01 = 6;
    localparam int REG_COL3_ROWS23 = 7;

    // plane codes, also bit positions in the outside mask
    localparam int PL_LEFT   = 0;
    localparam int PL_RIGHT  = 1;
    localparam int PL_BOTTOM = 2;
    localparam int PL_TOP    = 3;
    localparam int PL_NEAR   = 4;
    localparam int PL_FAR    = 5;

    typedef logic [CFG_DATA_W-1:0] t_cfg_word;

    // identity matrix
    localparam t_cfg_word CFG_RESET [NUM_REGS] = '{
        REG_COL0_ROWS01: 64'h0000_0000_0001_0000,
        REG_COL0_ROWS23: 64'h0000_0000_0000_0000,
        REG_COL1_ROWS01: 64'h0001_0000_0000_0000,
        REG_COL1_ROWS23: 64'h0000_0000_0000_0000,
        REG_COL2_ROWS01: 64'h0000_0000_0000_0000,
        REG_COL2_ROWS23: 64'h0000_0000_0001_0000,
        REG_COL3_ROWS01: 64'h0000_0000_0000_0000,
        REG_COL3_ROWS23: 64'h0001_0000_0000_0000
    };

endpackage

[sv/frustum_box_cull.sv]
// top level: view-frustum cull of axis-aligned boxes, one box per cycle unless the result channel stalls
//
//  channel   direction  handshake            payload
//  box in    in         i_valid / o_stall    i_min_x..i_max_z
//  result    out        o_valid / i_stall    o_visible, o_outside_mask
//  config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
//  one box per cycle sustained while i_stall is low; each box passes through the
//  input reg, 18 product regs, partial sum reg and result reg, in that order
//  clip planes are rebuilt from the matrix registers into plane registers after a write
//  synchronous active-low reset loads the identity matrix and empties the pipe
//  each stage holds under output stall and takes new data once it moves on
`include "frustum_box_cull_defines.svh"

module frustum_box_cull #(
    parameter int COORD_WIDTH = fbc_pkg::FBC_COORD_WIDTH,
    parameter int FRAC_BITS   = fbc_pkg::FBC_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fbc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fbc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [fbc_pkg::COORD_PORT_W-1:0] i_min_x,
    input  logic signed [fbc_pkg::COORD_PORT_W-1:0] i_min_y,
    input  logic signed [fbc_pkg::COORD_PORT_W-1:0] i_min_z,
    input  logic signed [fbc_pkg::COORD_PORT_W-1:0] i_max_x,
    input  logic signed [fbc_pkg::COORD_PORT_W-1:0] i_max_y,
    input  logic signed [fbc_pkg::COORD_PORT_W-1:0] i_max_z,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_visible,
    output logic [fbc_pkg::MASK_W-1:0]        o_outside_mask
);
    import fbc_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int PW = 2 * CW + 1;
    localparam int WW = CW + 1 + FRAC_BITS;
    localparam int SW = ((PW > WW) ? PW : WW) + 2;

    t_cfg_word r_cfg [NUM_REGS];

    logic signed [CW:0]   n_plane [NUM_PLANES][NUM_COMPS];
    logic signed [CW:0]   r_plane [NUM_PLANES][NUM_COMPS];

    logic                 r_v1, r_v2, r_v3, r_v4;
    logic                 w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    logic signed [CW-1:0] r_lo [NUM_AXES];
    logic signed [CW-1:0] r_hi [NUM_AXES];

    logic signed [CW-1:0] w_corner [NUM_PLANES][NUM_AXES];
    logic signed [PW-1:0] n_prod   [NUM_PLANES][NUM_AXES];
    logic signed [PW-1:0] r_prod   [NUM_PLANES][NUM_AXES];
    logic signed [WW-1:0] n_wt     [NUM_PLANES];
    logic signed [WW-1:0] r_wt     [NUM_PLANES];

    logic signed [SW-1:0] n_sa [NUM_PLANES];
    logic signed [SW-1:0] n_sb [NUM_PLANES];
    logic signed [SW-1:0] r_sa [NUM_PLANES];
    logic signed [SW-1:0] r_sb [NUM_PLANES];
    logic signed [SW-1:0] w_tot [NUM_PLANES];

    logic [MASK_W-1:0]    n_mask;
    logic [MASK_W-1:0]    r_mask;

    // per-stage ready, each stage moves when the next has room
    assign w_rdy4 = !r_v4 || !i_stall;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign o_stall        = !w_rdy1;
    assign o_valid        = r_v4;
    assign o_outside_mask = r_mask;
    assign o_visible      = (r_mask == '0);

    // clip planes: row 3 plus or minus row 0, 1 or 2
    for (genvar gp = 0; gp < NUM_PLANES; gp++) begin : g_plane
        localparam int ROW = gp / 2;
        for (genvar gi = 0; gi < NUM_COMPS; gi++) begin : g_comp
            logic signed [CW-1:0] w_ea;
            logic signed [CW-1:0] w_eb;
            assign w_ea = r_cfg[2 * gi + 1][32 +: CW];
            assign w_eb = r_cfg[2 * gi + ROW / 2][32 * (ROW % 2) +: CW];
            if (gp % 2 == 1) begin : g_minus
                assign n_plane[gp][gi] = {w_ea[CW-1], w_ea} - {w_eb[CW-1], w_eb};
            end else begin : g_plus
                assign n_plane[gp][gi] = {w_ea[CW-1], w_ea} + {w_eb[CW-1], w_eb};
            end
        end

        // furthest corner along the normal, then exact products
        for (genvar ga = 0; ga < NUM_AXES; ga++) begin : g_axis
            logic [PW-1:0] w_ext_p;
            logic [PW-1:0] w_ext_c;
            assign w_corner[gp][ga] = r_plane[gp][ga][CW] ? r_lo[ga] : r_hi[ga];
            assign w_ext_p = {{CW{r_plane[gp][ga][CW]}}, r_plane[gp][ga]};
            assign w_ext_c = {{(CW + 1){w_corner[gp][ga][CW-1]}}, w_corner[gp][ga]};
            assign n_prod[gp][ga] = $signed(w_ext_p) * $signed(w_ext_c);
        end

        assign n_wt[gp]  = WW'(r_plane[gp][NUM_AXES]) <<< FRAC_BITS;
        assign n_sa[gp]  = SW'(r_prod[gp][0]) + SW'(r_prod[gp][1]);
        assign n_sb[gp]  = SW'(r_prod[gp][2]) + SW'(r_wt[gp]);
        assign w_tot[gp] = r_sa[gp] + r_sb[gp];
        assign n_mask[gp] = w_tot[gp][SW-1] || (w_tot[gp] == '0);
    end

    // control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg[i_cfg_idx] <= i_cfg_data;
            end
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_plane <= n_plane;
        if (w_rdy1) begin
            r_lo[0] <= i_min_x[CW-1:0];
            r_lo[1] <= i_min_y[CW-1:0];
            r_lo[2] <= i_min_z[CW-1:0];
            r_hi[0] <= i_max_x[CW-1:0];
            r_hi[1] <= i_max_y[CW-1:0];
            r_hi[2] <= i_max_z[CW-1:0];
        end
        if (w_rdy2) begin
            r_prod <= n_prod;
            r_wt   <= n_wt;
        end
        if (w_rdy3) begin
            r_sa <= n_sa;
            r_sb <= n_sb;
        end
        if (w_rdy4) begin
            r_mask <= n_mask;
        end
    end

    `FBC_ASSERT_SAME(a_stall_full, i_clk, i_rst_n, o_stall, r_v1 && r_v2 && r_v3 && r_v4 && i_stall, "input stalled while the pipe has room")

    `FBC_ASSERT_NEXT(a_stage_out, i_clk, i_rst_n, r_v3 && w_rdy4, o_valid, "result lost between last stages")

    `FBC_ASSERT_SAME(a_visible, i_clk, i_rst_n, o_valid, o_visible == (o_outside_mask == '0), "visible disagrees with outside mask")

    for (genvar gc = 0; gc < NUM_COMPS; gc++) begin : g_chk
        `FBC_ASSERT_SAME(a_plane_pair, i_clk, i_rst_n, $past(i_rst_n), (CW + 2)'(r_plane[PL_LEFT][gc]) + (CW + 2)'(r_plane[PL_RIGHT][gc]) == (CW + 2)'(r_plane[PL_NEAR][gc]) + (CW + 2)'(r_plane[PL_FAR][gc]), "left and right planes do not pair with near and far")
    end

endmodule

[verif/testbench.sv]
// self-checking testbench for frustum_box_cull: directed boxes, then random boxes
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fbc_pkg::*;

    typedef struct packed {
        logic signed [COORD_PORT_W-1:0] min_x;
        logic signed [COORD_PORT_W-1:0] min_y;
        logic signed [COORD_PORT_W-1:0] min_z;
        logic signed [COORD_PORT_W-1:0] max_x;
        logic signed [COORD_PORT_W-1:0] max_y;
        logic signed [COORD_PORT_W-1:0] max_z;
    } t_box;

    typedef struct packed {
        logic              visible;
        logic [MASK_W-1:0] mask;
    } t_cull;

    typedef struct {
        t_box  box;
        bit    typed;
        t_cull want;
    } t_box_case;

    typedef enum int {
        MK_IDENTITY, MK_ZERO, MK_ONES, MK_MAX_POS, MK_MIN_NEG, MK_EXTREMES, MK_SCENE, MK_RANDOM
    } t_matrix_kind;

    localparam int IDLE_LIMIT  = 4000;
    localparam int PIPE_SETTLE = 8;
    localparam int HOLD_CYCLES = 200;
    localparam int HOLD_AFTER  = 500;

    localparam logic signed [31:0] Q_ONE      = 32'sh0001_0000;
    localparam logic signed [31:0] Q_TWO      = 32'sh0002_0000;
    localparam logic signed [31:0] Q_THREE    = 32'sh0003_0000;
    localparam logic signed [31:0] Q_UNDER    = 32'sh0000_ffff;
    localparam logic signed [31:0] Q_MIN      = 32'sh8000_0000;
    localparam logic signed [31:0] Q_MAX      = 32'sh7fff_ffff;

    localparam t_cull SEEN = '{1'b1, '0};

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [CFG_IDX_W-1:0]           i_cfg_idx;
    logic [CFG_DATA_W-1:0]          i_cfg_data;
    logic                           i_valid;
    logic                           o_stall;
    logic signed [COORD_PORT_W-1:0] i_min_x, i_min_y, i_min_z;
    logic signed [COORD_PORT_W-1:0] i_max_x, i_max_y, i_max_z;
    logic                           o_valid;
    logic                           i_stall;
    logic                           o_visible;
    logic [MASK_W-1:0]              o_outside_mask;

    frustum_box_cull i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_min_x        (i_min_x),
        .i_min_y        (i_min_y),
        .i_min_z        (i_min_z),
        .i_max_x        (i_max_x),
        .i_max_y        (i_max_y),
        .i_max_z        (i_max_z),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_visible      (o_visible),
        .o_outside_mask (o_outside_mask)
    );

    t_cfg_word matrix_regs [NUM_REGS] = CFG_RESET;
    t_cull     pending_culls [$];
    int        mismatches   = 0;
    int        results_seen = 0;
    int        idle_cycles  = 0;
    int        burst_left   = 0;

    t_box_case box_cases [18] = '{
        '{'{32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0}, 1'b1, SEEN},
        '{'{-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE}, 1'b1, SEEN},
        '{'{Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX}, 1'b1, SEEN},
        '{'{Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN}, 1'b1,
          '{1'b0, MASK_W'((1 << PL_LEFT) | (1 << PL_BOTTOM) | (1 << PL_NEAR))}},
        '{'{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX}, 1'b1,
          '{1'b0, MASK_W'((1 << PL_RIGHT) | (1 << PL_TOP) | (1 << PL_FAR))}},
        '{'{Q_TWO, -Q_ONE, -Q_ONE, Q_THREE, Q_ONE, Q_ONE}, 1'b1,
          '{1'b0, MASK_W'(1 << PL_RIGHT)}},
        '{'{-Q_THREE, -Q_ONE, -Q_ONE, -Q_TWO, Q_ONE, Q_ONE}, 1'b1,
          '{1'b0, MASK_W'(1 << PL_LEFT)}},
        '{'{-Q_ONE, Q_TWO, -Q_ONE, Q_ONE, Q_THREE, Q_ONE}, 1'b1,
          '{1'b0, MASK_W'(1 << PL_TOP)}},
        '{'{-Q_ONE, -Q_THREE, -Q_ONE, Q_ONE, -Q_TWO, Q_ONE}, 1'b1,
          '{1'b0, MASK_W'(1 << PL_BOTTOM)}},
        '{'{-Q_ONE, -Q_ONE, Q_TWO, Q_ONE, Q_ONE, Q_THREE}, 1'b1,
          '{1'b0, MASK_W'(1 << PL_FAR)}},
        '{'{-Q_ONE, -Q_ONE, -Q_THREE, Q_ONE, Q_ONE, -Q_TWO}, 1'b1,
          '{1'b0, MASK_W'(1 << PL_NEAR)}},
        '{'{Q_ONE, -Q_ONE, -Q_ONE, Q_TWO, Q_ONE, Q_ONE}, 1'b1,
          '{1'b0, MASK_W'(1 << PL_RIGHT)}},
        '{'{-Q_TWO, -Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE}, 1'b1,
          '{1'b0, MASK_W'(1 << PL_LEFT)}},
        '{'{Q_UNDER, -Q_ONE, -Q_ONE, Q_TWO, Q_ONE, Q_ONE}, 1'b1, SEEN},
        '{'{Q_ONE, Q_ONE, Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE}, 1'b1, '{1'b0, '1}},
        '{'{Q_MAX, 32'sh0, Q_MIN, Q_MIN, 32'sh0, Q_MAX}, 1'b0, SEEN},
        '{'{-Q_TWO, Q_THREE, 32'sh0, Q_THREE, -Q_THREE, Q_ONE}, 1'b0, SEEN},
        '{'{32'sh1234_5678, -32'sh0fed_cba9, 32'sh0000_0001,
            32'sh5555_5555, 32'sh2aaa_aaaa, -32'sh0000_0001}, 1'b0, SEEN}
    };

    function automatic logic signed [31:0] mat_entry(int col, int row);
        t_cfg_word word;
        word = matrix_regs[2 * col + row / 2];
        return (row % 2) ? word[63:32] : word[31:0];
    endfunction

    function automatic t_cull cull_planes(t_box b);
        logic signed [31:0]  lo [NUM_AXES];
        logic signed [31:0]  hi [NUM_AXES];
        logic signed [32:0]  comp [NUM_COMPS];
        logic signed [32:0]  w_row, k_row;
        logic signed [31:0]  coord;
        logic signed [127:0] acc, prod;
        t_cull               r;
        lo = '{b.min_x, b.min_y, b.min_z};
        hi = '{b.max_x, b.max_y, b.max_z};
        r.mask = '0;
        for (int p = 0; p < NUM_PLANES; p++) begin
            for (int i = 0; i < NUM_COMPS; i++) begin
                w_row = mat_entry(i, 3);
                k_row = mat_entry(i, p / 2);
                comp[i] = (p % 2) ? w_row - k_row : w_row + k_row;
            end
            acc = comp[3];
            acc = acc <<< FBC_FRAC_BITS;
            for (int i = 0; i < NUM_AXES; i++) begin
                coord = (comp[i] < 0) ? lo[i] : hi[i];
                prod = coord;
                prod = prod * comp[i];
                acc = acc + prod;
            end
            if (acc <= 0) begin
                r.mask[p] = 1'b1;
            end
        end
        r.visible = (r.mask == '0);
        return r;
    endfunction

    function automatic logic signed [31:0] extreme_coord();
        case ($urandom_range(0, 5))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return 32'sh0;
            3: return 32'sh1;
            4: return -32'sh1;
            default: return Q_ONE;
        endcase
    endfunction

    function automatic t_box random_box();
        logic signed [31:0] lo [NUM_AXES];
        logic signed [31:0] hi [NUM_AXES];
        logic signed [31:0] ctr, half, tmp;
        int                 shape;
        t_box               b;
        shape = $urandom_range(0, 9);
        for (int a = 0; a < NUM_AXES; a++) begin
            if (shape <= 8) begin
                ctr = $signed(32'($urandom_range(0, 32'h10_0000))) - 32'sh8_0000;
                half = ($urandom_range(0, 7) == 0) ? 32'($urandom_range(0, 32'h2000_0000))
                                                   : 32'($urandom_range(0, 32'h4_0000));
                lo[a] = ctr - half;
                hi[a] = ctr + half;
                if (shape == 8 && $urandom_range(0, 1)) begin
                    tmp = lo[a];
                    lo[a] = hi[a];
                    hi[a] = tmp;
                end
                if (shape == 7) begin
                    lo[a] = $urandom;
                    hi[a] = $urandom;
                end
            end else begin
                lo[a] = extreme_coord();
                hi[a] = extreme_coord();
            end
        end
        b = '{lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
        return b;
    endfunction

    task automatic load_matrix(input t_matrix_kind kind);
        logic signed [31:0] e;
        for (int col = 0; col < NUM_COMPS; col++) begin
            for (int row = 0; row < NUM_COMPS; row++) begin
                case (kind)
                    MK_ZERO:     e = '0;
                    MK_ONES:     e = '1;
                    MK_MAX_POS:  e = Q_MAX;
                    MK_MIN_NEG:  e = Q_MIN;
                    MK_EXTREMES: e = extreme_coord();
                    MK_SCENE: begin
                        if (row == 3 && col == 3) begin
                            e = 32'($urandom_range(32'h8000, 32'h4_0000));
                        end else begin
                            e = $signed(32'($urandom_range(0, 32'h4_0000))) - 32'sh2_0000;
                        end
                    end
                    default:     e = $urandom;
                endcase
                matrix_regs[2 * col + row / 2][32 * (row % 2) +: 32] = e;
            end
        end
        if (kind == MK_IDENTITY) begin
            matrix_regs = CFG_RESET;
        end
        for (int r = REG_COL0_ROWS01; r <= REG_COL3_ROWS23; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(r);
            i_cfg_data <= matrix_regs[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_box(input t_box b, input bit typed, input t_cull typed_result);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_min_x <= b.min_x;
        i_min_y <= b.min_y;
        i_min_z <= b.min_z;
        i_max_x <= b.max_x;
        i_max_y <= b.max_y;
        i_max_z <= b.max_z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_culls.push_back(typed ? typed_result : cull_planes(b));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_culls.size() != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stall pattern, with one long hold-off to back up the pipe
    initial begin
        int kind, span;
        bit held_off;
        held_off = 1'b0;
        i_stall <= 1'b0;
        forever begin
            kind = $urandom_range(0, 3);
            span = $urandom_range(1, 40);
            if (!held_off && results_seen >= HOLD_AFTER) begin
                held_off = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                for (int k = 0; k < span; k++) begin
                    case (kind)
                        0: i_stall <= 1'b0;
                        1: i_stall <= 1'($urandom_range(0, 1));
                        2: i_stall <= ($urandom_range(0, 3) == 0);
                        default: i_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_cull got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_visible, o_outside_mask};
            results_seen++;
            if (pending_culls.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result transfer with nothing pending: visible=%0b mask=%b",
                             got.visible, got.mask);
                end
            end else begin
                want = pending_culls.pop_front();
                if (got.visible !== want.visible || got.mask !== want.mask) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d: expected vis=%0b mask=%b, got vis=%0b mask=%b",
                                 results_seen, want.visible, want.mask, got.visible, got.mask);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("frustum_box_cull: mismatch");
            $finish;
        end
    end

    initial begin
        t_matrix_kind plan [$];
        int           r, count;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        i_valid    <= 1'b0;
        i_min_x    <= '0;
        i_min_y    <= '0;
        i_min_z    <= '0;
        i_max_x    <= '0;
        i_max_y    <= '0;
        i_max_z    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (box_cases[n]) begin
            send_box(box_cases[n].box, box_cases[n].typed, box_cases[n].want);
        end
        drain();

        plan = '{MK_ZERO, MK_ONES, MK_MAX_POS, MK_MIN_NEG, MK_EXTREMES};
        for (int n = 0; n < 9; n++) begin
            r = $urandom_range(0, 9);
            plan.push_back(r < 7 ? MK_SCENE : (r < 9 ? MK_RANDOM : MK_IDENTITY));
        end
        foreach (plan[n]) begin
            load_matrix(plan[n]);
            count = (plan[n] == MK_SCENE || plan[n] == MK_RANDOM || plan[n] == MK_IDENTITY)
                    ? 190 : 40;
            for (int k = 0; k < count; k++) begin
                send_box(random_box(), 1'b0, SEEN);
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("frustum_box_cull: match");
        end else begin
            $display("frustum_box_cull: mismatch");
        end
        $finish;
    end

endmodule
